// ===== src/ps2md_pkg.sv =====
// shared types, constants and helpers for the ps/2 mouse packet decoder
package ps2md_pkg;

    localparam int POS_WIDTH = 12;
    localparam int CFG_WIDTH = 12;
    localparam int CUR_WIDTH = 12;
    localparam int SUM_WIDTH = POS_WIDTH + 2;

    localparam logic [7:0] ACK_BYTE = 8'hFA;
    localparam int HDR_LEFT_BIT   = 0;
    localparam int HDR_RIGHT_BIT  = 1;
    localparam int HDR_MIDDLE_BIT = 2;
    localparam int HDR_SYNC_BIT   = 3;
    localparam int HDR_XSIGN_BIT  = 4;
    localparam int HDR_YSIGN_BIT  = 5;

    localparam logic [CFG_WIDTH-1:0] WIDTH_RESET  = CFG_WIDTH'(320);
    localparam logic [CFG_WIDTH-1:0] HEIGHT_RESET = CFG_WIDTH'(200);
    localparam logic [POS_WIDTH-1:0] POS_X_RESET  = POS_WIDTH'(160);
    localparam logic [POS_WIDTH-1:0] POS_Y_RESET  = POS_WIDTH'(100);
    localparam logic [POS_WIDTH-1:0] POS_MAX      = '1;

    typedef enum logic [1:0] {
        STAGE_HEADER   = 2'd0,
        STAGE_X        = 2'd1,
        STAGE_Y        = 2'd2,
        STAGE_WAIT_ACK = 2'd3
    } t_stage;

    typedef enum logic [0:0] {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } t_cfg_idx;

    // largest legal coordinate for a screen size; zero size acts as one
    function automatic logic [POS_WIDTH-1:0] clamp_top(input logic [CFG_WIDTH-1:0] lim);
        logic [CFG_WIDTH-1:0] t;
        t = (lim == '0) ? '0 : lim - CFG_WIDTH'(1);
        if (32'(t) > 32'(POS_MAX)) begin
            return POS_MAX;
        end
        return POS_WIDTH'(t);
    endfunction

endpackage

// ===== src/ps2md_if.sv =====
// valid/ready channel interfaces for received bytes, decoded results and configuration
interface ps2md_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2md_result_if import ps2md_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic                        left_pressed;
    logic                        right_pressed;
    logic                        middle_pressed;
    logic signed [8:0]           delta_x;
    logic signed [9:0]           delta_y;
    logic [CUR_WIDTH-1:0]        cursor_x;
    logic [CUR_WIDTH-1:0]        cursor_y;

    modport source (output valid, output left_pressed, output right_pressed,
                    output middle_pressed, output delta_x, output delta_y,
                    output cursor_x, output cursor_y, input ready);
    modport sink   (input valid, input left_pressed, input right_pressed,
                    input middle_pressed, input delta_x, input delta_y,
                    input cursor_x, input cursor_y, output ready);
endinterface

interface ps2md_cfg_if import ps2md_pkg::*;;
    logic                 valid;
    logic                 ready;
    t_cfg_idx             index;
    logic [CFG_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/ps2_mouse_packet_decoder_core.sv =====
// ps/2 mouse three-byte packet decoder: framing, button/delta decode and clamped cursor
// Takes one received mouse byte per clock on i_byte; after reset bytes are dropped until
// the 0xFA acknowledge, then 3-byte packets are framed (a header needs bit 3 set, else it
// is dropped to resync). Every byte is decoded in the cycle it is transferred, and the
// third byte of a packet loads the result register, so the result appears on o_result
// in the next cycle. Sustained rate is one byte per cycle; the only stall is a third byte
// arriving while an earlier result still sits untaken in the single result register.
// Screen size writes on i_cfg are taken at any time and apply from the next packet on;
// the cursor is not re-clamped until then.
module ps2_mouse_packet_decoder_core import ps2md_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    ps2md_byte_if.sink              i_byte,
    ps2md_cfg_if.sink               i_cfg,
    ps2md_result_if.source          o_result
);

    t_stage                 r_stage, n_stage;
    logic [7:0]             r_header;
    logic [7:0]             r_x_byte;
    logic [POS_WIDTH-1:0]   r_pos_x, n_pos_x;
    logic [POS_WIDTH-1:0]   r_pos_y, n_pos_y;
    logic [POS_WIDTH-1:0]   r_top_x;
    logic [POS_WIDTH-1:0]   r_top_y;
    logic                   r_out_valid;

    logic                   byte_xfer;
    logic                   pkt_done;
    logic signed [8:0]      dx;
    logic signed [9:0]      dy;
    logic signed [SUM_WIDTH-1:0] sum_x;
    logic signed [SUM_WIDTH-1:0] sum_y;

    // a result-free byte never waits on the output side
    assign i_byte.ready = (r_stage != STAGE_Y) || !r_out_valid || o_result.ready;
    assign byte_xfer    = i_byte.valid && i_byte.ready;
    assign i_cfg.ready  = 1'b1;

    // next state
    always_comb begin
        n_stage = r_stage;
        if (byte_xfer) begin
            unique case (r_stage)
                STAGE_HEADER: begin
                    if (i_byte.rx_byte[HDR_SYNC_BIT]) begin
                        n_stage = STAGE_X;
                    end
                end
                STAGE_X:        n_stage = STAGE_Y;
                STAGE_Y:        n_stage = STAGE_HEADER;
                STAGE_WAIT_ACK: begin
                    if (i_byte.rx_byte == ACK_BYTE) begin
                        n_stage = STAGE_HEADER;
                    end
                end
                default:        n_stage = STAGE_WAIT_ACK;
            endcase
        end
    end

    // packet decode and cursor update
    always_comb begin
        pkt_done = byte_xfer && (r_stage == STAGE_Y);
        dx       = {r_header[HDR_XSIGN_BIT], r_x_byte};
        dy       = -$signed({r_header[HDR_YSIGN_BIT], r_header[HDR_YSIGN_BIT],
                             i_byte.rx_byte});
        sum_x    = $signed({2'b00, r_pos_x}) + SUM_WIDTH'(dx);
        sum_y    = $signed({2'b00, r_pos_y}) + SUM_WIDTH'(dy);

        if (sum_x < 0) begin
            n_pos_x = '0;
        end else if (sum_x > $signed({2'b00, r_top_x})) begin
            n_pos_x = r_top_x;
        end else begin
            n_pos_x = sum_x[POS_WIDTH-1:0];
        end

        if (sum_y < 0) begin
            n_pos_y = '0;
        end else if (sum_y > $signed({2'b00, r_top_y})) begin
            n_pos_y = r_top_y;
        end else begin
            n_pos_y = sum_y[POS_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= STAGE_WAIT_ACK;
            r_pos_x     <= POS_X_RESET;
            r_pos_y     <= POS_Y_RESET;
            r_top_x     <= clamp_top(WIDTH_RESET);
            r_top_y     <= clamp_top(HEIGHT_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_stage <= n_stage;
            if (pkt_done) begin
                r_pos_x     <= n_pos_x;
                r_pos_y     <= n_pos_y;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_SCREEN_WIDTH:  r_top_x <= clamp_top(i_cfg.data);
                    CFG_SCREEN_HEIGHT: r_top_y <= clamp_top(i_cfg.data);
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (byte_xfer && (r_stage == STAGE_HEADER) && i_byte.rx_byte[HDR_SYNC_BIT]) begin
            r_header <= i_byte.rx_byte;
        end
        if (byte_xfer && (r_stage == STAGE_X)) begin
            r_x_byte <= i_byte.rx_byte;
        end
        if (pkt_done) begin
            o_result.left_pressed   <= r_header[HDR_LEFT_BIT];
            o_result.right_pressed  <= r_header[HDR_RIGHT_BIT];
            o_result.middle_pressed <= r_header[HDR_MIDDLE_BIT];
            o_result.delta_x        <= dx;
            o_result.delta_y        <= dy;
            o_result.cursor_x       <= CUR_WIDTH'(n_pos_x);
            o_result.cursor_y       <= CUR_WIDTH'(n_pos_y);
        end
    end

    assign o_result.valid = r_out_valid;

endmodule
